// ----- design/dds_pkg.sv -----
// Shared constants, types and the quarter-wave sine table builder for the tone generator.
package dds_pkg;

    // Phase accumulator and table geometry.
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
    localparam int MAX_CHANNELS    = 8;

    // Field widths of the channels and registers.
    localparam int STEP_BITS   = 31;
    localparam int AMP_BITS    = 15;
    localparam int COUNT_BITS  = 4;
    localparam int CH_BITS     = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 31;
    localparam int CFG_IDX_BITS = 2;

    // Q30 sine values, the quarter point needs one bit above the fraction.
    localparam int Q_FRAC   = 30;
    localparam int ROM_BITS = Q_FRAC + 1;
    localparam int MUL_BITS = AMP_BITS + ROM_BITS;
    localparam int MAG_BITS = MUL_BITS - Q_FRAC;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Request queue depth.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP    = 2'd0,
        CFG_AMPLITUDE     = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } t_cfg_idx;

    // One classified frame request: table address and sign of the sample.
    typedef struct packed {
        logic                       neg;
        logic [TABLE_ADDR_BITS:0]   addr;
    } t_req;

    typedef logic [ROM_BITS-1:0] t_rom [0:TBL_N];

    // Truncating integer Taylor series of sin(x), x in Q30, result clamped to [0, 1.0].
    function automatic logic [ROM_BITS-1:0] f_sin_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> Q_FRAC;
        term = x;
        sum  = $signed(x);
        // Ten terms of alternating sign; term n is divided by (2n)(2n+1).
        term = ((term * x2) >> Q_FRAC) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd210;
        sum  = sum - $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd272;
        sum  = sum + $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd342;
        sum  = sum - $signed(term);
        term = ((term * x2) >> Q_FRAC) / 64'd420;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > $signed(Q30_ONE)) begin
            sum = $signed(Q30_ONE);
        end
        return sum[ROM_BITS-1:0];
    endfunction

    // Quarter-wave table with one extra entry for the quarter point.
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] x;
        for (int k = 0; k < TBL_N; k++) begin
            x      = (64'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
            rom[k] = f_sin_q30(x);
        end
        rom[0]     = '0;
        rom[TBL_N] = Q30_ONE[ROM_BITS-1:0];
        return rom;
    endfunction

endpackage

// ----- design/dds_in_if.sv -----
// Request channel: one tick per frame request.
interface dds_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

// ----- design/dds_out_if.sv -----
// Sample channel: one PCM sample copy per channel of a frame.
interface dds_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic [2:0]  channel;
    logic        last;

    modport source (output valid, output sample, output channel, output last, input ready);
    modport sink (input valid, input sample, input channel, input last, output ready);
endinterface

// ----- design/dds_front.sv -----
// Front end: accepts tick requests, keeps the phase accumulator and forms table requests.
module dds_front
    import dds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dds_in_if.sink               i_in,
    input  logic [STEP_BITS-1:0] i_phase_step,
    input  logic                 i_fifo_full,
    output logic                 o_push,
    output t_req                 o_req
);

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] idx;

    // Requests are taken whenever the queue has room; a zero tick is dropped.
    assign i_in.ready = !i_fifo_full;
    assign o_push     = i_in.valid && !i_fifo_full && i_in.tick;

    // Quadrant and table index from the top phase bits, mirrored in odd quadrants.
    assign quad = r_phase[PHASE_BITS-1 -: 2];
    assign idx  = r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    always_comb begin
        o_req.neg = quad[1];
        if (quad[0]) begin
            o_req.addr = (TABLE_ADDR_BITS+1)'(TBL_N) - {1'b0, idx};
        end else begin
            o_req.addr = {1'b0, idx};
        end
    end

    // Phase advances once per frame with natural wrap.
    assign n_phase = r_phase + PHASE_BITS'(i_phase_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ----- design/dds_req_fifo.sv -----
// Short queue of frame requests between the front end and the sample back end.
module dds_req_fifo
    import dds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_req o_req
);

    t_req                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

    // Storage has no reset; only occupied entries are ever read.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/dds_back.sv -----
// Back end: table read, amplitude scaling, saturation and per-channel replication.
module dds_back
    import dds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  t_req                i_req,
    output logic                o_pop,
    input  logic [AMP_BITS-1:0] i_amplitude,
    input  logic [CH_BITS-1:0]  i_last_ch,
    dds_out_if.source           o_out
);

    localparam t_rom SIN_ROM = f_build_rom();

    // Table read stage.
    logic                r_t_valid;
    logic [ROM_BITS-1:0] r_t_sin;
    logic                r_t_neg;
    // Multiply stage.
    logic                r_m_valid;
    logic [MAG_BITS-1:0] r_m_mag;
    logic                r_m_neg;
    // Emit stage, which is also the output register.
    logic                   r_e_valid;
    logic [SAMPLE_BITS-1:0] r_e_sample;
    logic [CH_BITS-1:0]     r_e_ch;

    logic                   e_last;
    logic                   e_load;
    logic                   m_adv;
    logic                   t_adv;
    logic [MUL_BITS-1:0]    product;
    logic [SAMPLE_BITS-1:0] n_sample;

    // Stage handoff: each stage moves on when the next one is free or freeing.
    assign e_last = (r_e_ch == i_last_ch);
    assign e_load = !r_e_valid || (o_out.ready && e_last);
    assign m_adv  = !r_m_valid || e_load;
    assign t_adv  = !r_t_valid || m_adv;
    assign o_pop  = i_req_valid && t_adv;

    assign o_out.valid   = r_e_valid;
    assign o_out.sample  = r_e_sample;
    assign o_out.channel = r_e_ch;
    assign o_out.last    = e_last;

    // Registered table read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (t_adv) begin
            r_t_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_t_sin <= SIN_ROM[i_req.addr];
            r_t_neg <= i_req.neg;
        end
    end

    // Amplitude times sine, truncated toward zero by dropping the Q30 fraction.
    assign product = MUL_BITS'(i_amplitude) * MUL_BITS'(r_t_sin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_adv) begin
            r_m_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_adv && r_t_valid) begin
            r_m_mag <= product[MUL_BITS-1:Q_FRAC];
            r_m_neg <= r_t_neg;
        end
    end

    // Apply the sign and saturate to the 16-bit sample range.
    always_comb begin
        if (r_m_neg) begin
            if (r_m_mag > MAG_BITS'(32768)) begin
                n_sample = 16'h8000;
            end else begin
                n_sample = SAMPLE_BITS'(-r_m_mag);
            end
        end else begin
            if (r_m_mag > MAG_BITS'(32767)) begin
                n_sample = 16'h7FFF;
            end else begin
                n_sample = SAMPLE_BITS'(r_m_mag);
            end
        end
    end

    // Emit one copy per cycle while the output is ready, counting the channel up to the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_ch    <= '0;
        end else if (e_load) begin
            r_e_valid <= r_m_valid;
            r_e_ch    <= '0;
        end else if (o_out.ready) begin
            r_e_ch <= r_e_ch + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load && r_m_valid) begin
            r_e_sample <= n_sample;
        end
    end

endmodule

// ----- design/dds_sine_tone_generator.sv -----
// Top level of the sine tone generator: configuration registers and the front/back split.
//
//   channel  | dir | payload                        | request meaning
//   i_in     | in  | tick                           | one frame when tick is 1
//   o_out    | out | sample[15:0], channel[2:0], last | one channel copy of a sample
//   i_cfg_*  | in  | idx[1:0], data[30:0]           | register write, no handshake
//
// A frame with N channels gives N copies on the output, one copy per cycle while the output
// is ready; frames follow back to back.
// When a request is accepted, the queue is written at the accepting edge, and the sample
// then passes through the table read, multiply and emit registers.
// Reset clears the phase, the registers (channel count to 1) and all stage valid bits.
// Output stalls hold the emit stage; the stages behind it and a two-entry queue keep
// taking requests until full, and a zero tick is accepted and dropped.
module dds_sine_tone_generator
    import dds_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    dds_in_if.sink                  i_in,
    dds_out_if.source               o_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    logic [STEP_BITS-1:0] r_phase_step;
    logic [AMP_BITS-1:0]  r_amplitude;
    logic [CH_BITS-1:0]   r_last_ch;
    logic [CH_BITS-1:0]   n_last_ch;
    logic [COUNT_BITS-1:0] count;

    logic fifo_push;
    logic fifo_full;
    logic fifo_valid;
    logic fifo_pop;
    t_req push_req;
    t_req pop_req;

    // Channel count clamped to 1..MAX_CHANNELS, kept as the index of the last copy.
    assign count = i_cfg_data[COUNT_BITS-1:0];

    always_comb begin
        if (count == '0) begin
            n_last_ch = '0;
        end else if (count > COUNT_BITS'(MAX_CHANNELS)) begin
            n_last_ch = CH_BITS'(MAX_CHANNELS - 1);
        end else begin
            n_last_ch = CH_BITS'(count - 1'b1);
        end
    end

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_amplitude  <= '0;
            r_last_ch    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_STEP:    r_phase_step <= i_cfg_data[STEP_BITS-1:0];
                CFG_AMPLITUDE:     r_amplitude  <= i_cfg_data[AMP_BITS-1:0];
                CFG_CHANNEL_COUNT: r_last_ch    <= n_last_ch;
                default:           r_last_ch    <= r_last_ch;
            endcase
        end
    end

    dds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_phase_step (r_phase_step),
        .i_fifo_full  (fifo_full),
        .o_push       (fifo_push),
        .o_req        (push_req)
    );

    dds_req_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_req   (push_req),
        .i_pop   (fifo_pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_req   (pop_req)
    );

    dds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (fifo_valid),
        .i_req       (pop_req),
        .o_pop       (fifo_pop),
        .i_amplitude (r_amplitude),
        .i_last_ch   (r_last_ch),
        .o_out       (o_out)
    );

endmodule

// ----- tb/tb_dds_sine_tone_generator.sv -----
// Self-checking testbench for the sine tone generator: directed table, then random frames.
module tb_dds_sine_tone_generator;
    import dds_pkg::*;

    typedef longint unsigned u64_t;

    // One channel copy of a PCM sample as the block should emit it.
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CH_BITS-1:0]            channel;
        logic                          last;
    } pcm_copy_t;

    // A directed row either writes a register or sends one frame request.
    typedef enum logic {
        ROW_WRITE,
        ROW_TICK
    } row_kind_e;

    typedef struct {
        row_kind_e                     kind;
        logic [CFG_IDX_BITS-1:0]       idx;
        logic [CFG_BITS-1:0]           data;
        logic                          tick;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] sample;
    } row_t;

    localparam logic [CFG_IDX_BITS-1:0]       CFG_IDX_SPARE = 2'd3;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX    = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN    = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG      = -16'sd32767;
    localparam logic [CFG_BITS-1:0]           QUARTER_TURN  = 31'h4000_0000;
    localparam logic [CFG_BITS-1:0]           ALL_ONES      = 31'h7FFF_FFFF;
    localparam int COPY_LIMIT      = 8;
    localparam int IDLE_PERCENT    = 34;
    localparam int ZERO_PERCENT    = 12;
    localparam int RANDOM_REQUESTS = 320;
    localparam int SETTLE_CYCLES   = 16;
    localparam int STALL_LIMIT     = 2000;
    localparam int REPORT_LIMIT    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;

    dds_in_if  in_if ();
    dds_out_if out_if ();

    dds_sine_tone_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: phase accumulator, registers and the quarter-wave table.
    u64_t                   sine_quarter [0:TBL_N];
    logic [PHASE_BITS-1:0]  phase_acc;
    logic [STEP_BITS-1:0]   step_reg;
    logic [AMP_BITS-1:0]    amp_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    pcm_copy_t pcm_expected [$];
    int        fault_count = 0;
    bit        no_idle     = 1'b0;

    // Directed stimulus: quadrant peaks at full scale, channel count limits, masking.
    row_t directed_rows [$] = '{
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_AMPLITUDE,     31'd32767,     1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_PHASE_STEP,    QUARTER_TURN,  1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 31'd0,         1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, SAMPLE_MAX},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, PEAK_NEG},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 31'd8,         1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, SAMPLE_MAX},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 31'd15,        1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_IDX_SPARE,     ALL_ONES,      1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b1, PEAK_NEG},
        '{ROW_WRITE, CFG_AMPLITUDE,     31'h4000_0005, 1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_PHASE_STEP,    ALL_ONES,      1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 31'd9,         1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_AMPLITUDE,     ALL_ONES,      1'b0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 31'h7FFF_FFF3, 1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b0, 1'b0, 16'sd0},
        '{ROW_TICK,  CFG_PHASE_STEP,    31'd0,         1'b1, 1'b0, 16'sd0}
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Truncating integer Taylor series of sin(x) with x in Q30, clamped to [0, 1.0].
    function automatic u64_t taylor_sine(input u64_t x);
        u64_t   x2;
        u64_t   term;
        longint acc;
        x2   = (x * x) >> Q_FRAC;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> Q_FRAC) / u64_t'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(Q30_ONE)) begin
            acc = longint'(Q30_ONE);
        end
        return u64_t'(acc);
    endfunction

    // Expected copies of one frame at the current phase; the phase then advances.
    function automatic void predict_frame(input bit typed,
                                          input logic signed [SAMPLE_BITS-1:0] typed_sample);
        logic [1:0]                    quad;
        logic [TABLE_ADDR_BITS-1:0]    addr;
        u64_t                          mag;
        logic signed [SAMPLE_BITS-1:0] pcm;
        int                            copies;
        quad = phase_acc[PHASE_BITS-1 -: 2];
        addr = phase_acc[PHASE_BITS-3 -: TABLE_ADDR_BITS];
        mag  = quad[0] ? sine_quarter[TBL_N - addr] : sine_quarter[addr];
        mag  = (mag * amp_reg) >> Q_FRAC;
        if (quad[1]) begin
            pcm = (mag > 32768) ? SAMPLE_MIN : SAMPLE_BITS'(u64_t'(0) - mag);
        end else begin
            pcm = (mag > 32767) ? SAMPLE_MAX : SAMPLE_BITS'(mag);
        end
        if (typed) begin
            pcm = typed_sample;
        end
        // A count of zero means one copy; large counts saturate.
        copies = (count_reg == 0) ? 1 : int'(count_reg);
        if (copies > MAX_CHANNELS) begin
            copies = MAX_CHANNELS;
        end
        if (copies > COPY_LIMIT) begin
            copies = COPY_LIMIT;
        end
        for (int ch = 0; ch < copies; ch++) begin
            pcm_expected.push_back('{pcm, CH_BITS'(ch), (ch == copies - 1)});
        end
        phase_acc = phase_acc + step_reg;
    endfunction

    // Register write: drives the write enable, index and data, masked to the register width.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PHASE_STEP:    step_reg  = data[STEP_BITS-1:0];
            CFG_AMPLITUDE:     amp_reg   = data[AMP_BITS-1:0];
            CFG_CHANNEL_COUNT: count_reg = data[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Send one frame request after a random gap, predicting once it is accepted.
    task automatic push_request(input logic tick_bit, input bit typed,
                                input logic signed [SAMPLE_BITS-1:0] typed_sample);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                gap++;
            end
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.tick  <= tick_bit;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        if (tick_bit) begin
            predict_frame(typed, typed_sample);
        end
    endtask

    // Stop requesting, wait for every expected copy, then give a zero tick time to drain.
    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (pcm_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output side: random stalls, each accepted copy compared with the oldest expectation.
    always @(posedge i_clk) begin : sample_sink
        pcm_copy_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pcm_expected.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("unexpected copy: sample %0d channel %0d last %0b",
                             $signed(out_if.sample), out_if.channel, out_if.last);
                end
            end else begin
                want = pcm_expected.pop_front();
                if (out_if.sample !== want.sample || out_if.channel !== want.channel ||
                        out_if.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("mismatch: expected sample %0d channel %0d last %0b, got %0d %0d %0b",
                                 want.sample, want.channel, want.last,
                                 $signed(out_if.sample), out_if.channel, out_if.last);
                    end
                end
            end
        end
        out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (in_if.valid && in_if.ready) ||
                    (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("dds_sine_tone_generator test failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final verdict.
    initial begin : stimulus
        bit   writing;
        int   requests_sent;
        int   phase_no;
        int   burst;
        logic tick_bit;
        logic [STEP_BITS-1:0]  step_val;
        logic [AMP_BITS-1:0]   amp_val;
        logic [COUNT_BITS-1:0] count_val;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_PHASE_STEP;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.tick   = 1'b0;
        out_if.ready = 1'b0;

        for (int k = 0; k < TBL_N; k++) begin
            sine_quarter[k] = taylor_sine((u64_t'(k) * HALF_PI_Q30) >> TABLE_ADDR_BITS);
        end
        sine_quarter[0]     = 0;
        sine_quarter[TBL_N] = Q30_ONE;
        phase_acc = '0;
        step_reg  = '0;
        amp_reg   = '0;
        count_reg = 4'd1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; writes only once the block has gone quiet.
        writing = 1'b0;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                if (!writing) begin
                    settle_block();
                    writing = 1'b1;
                end
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                if (writing) begin
                    i_cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                push_request(directed_rows[r].tick, directed_rows[r].typed,
                             directed_rows[r].sample);
            end
        end

        // Random phases: new settings, then a burst of mostly nonzero ticks.
        requests_sent = 0;
        phase_no      = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            settle_block();
            no_idle = (phase_no >= 2 && phase_no <= 4);
            case ($urandom_range(5))
                0:       step_val = '0;
                1:       step_val = '1;
                2:       step_val = STEP_BITS'($urandom_range(1, 1 << 22));
                default: step_val = STEP_BITS'($urandom());
            endcase
            case ($urandom_range(3))
                0:       amp_val = '0;
                1:       amp_val = '1;
                default: amp_val = AMP_BITS'($urandom());
            endcase
            count_val = COUNT_BITS'($urandom_range(15));
            write_reg(CFG_PHASE_STEP, step_val);
            write_reg(CFG_AMPLITUDE, {16'($urandom()), amp_val});
            write_reg(CFG_CHANNEL_COUNT, {27'($urandom()), count_val});
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_IDX_SPARE, CFG_BITS'($urandom()));
            end
            i_cfg_we <= 1'b0;
            burst = $urandom_range(8, 40);
            repeat (burst) begin
                tick_bit = ($urandom_range(99) >= ZERO_PERCENT);
                push_request(tick_bit, 1'b0, 16'sd0);
                requests_sent++;
            end
            phase_no++;
        end
        no_idle = 1'b0;
        settle_block();

        fault_count += pcm_expected.size();
        if (fault_count == 0) begin
            $display("dds_sine_tone_generator test passed");
        end else begin
            $display("dds_sine_tone_generator test failed");
        end
        $finish;
    end

endmodule
